[sv/stg_pkg.sv]
// Shared constants, types and quarter-wave table builder for the sine tone generator.
package stg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 12;
    localparam int QUARTER_BITS    = TABLE_ADDR_BITS - 2;
    localparam int QUARTER_LEN     = 1 << QUARTER_BITS;
    localparam int ROM_ADDR_BITS   = QUARTER_BITS + 1;
    localparam int SAMPLE_BITS     = 16;
    localparam int MAG_BITS        = SAMPLE_BITS - 1;
    localparam int MAX_CHANNELS    = 8;
    localparam int CHAN_BITS       = 3;
    localparam int COUNT_BITS      = 4;
    localparam int STEP_BITS       = 32;
    localparam int CFG_INDEX_BITS  = 1;

    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET    = 32'd39370534;
    localparam logic [COUNT_BITS-1:0] CHANNEL_COUNT_RESET = 4'd1;
    localparam logic [STEP_BITS-1:0]  HALF_SCALE          = 32'h8000_0000;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 1'b1;

    // pi/2 in unsigned Q2.62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] AMPLITUDE   = 64'((64'd1 << MAG_BITS) - 64'd1);

    typedef logic [MAG_BITS-1:0] t_mag;
    typedef t_mag t_quarter_rom [0:QUARTER_LEN];

    // floor(a * b / 2^sh), low 64 bits
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod >> sh);
    endfunction

    // sine of a Q2.62 angle in [0, pi/2], Taylor series to the x^27 term
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_shr(x, x, 62);
        term = x;
        sum  = x;
        for (int n = 1; n <= 13; n++) begin
            term = mul_shr(term, x2, 62) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Build the quarter-wave magnitude table, evaluated at elaboration only
    function automatic t_quarter_rom build_quarter_rom();
        t_quarter_rom rom;
        logic [63:0]  coarse;
        logic [63:0]  fine;
        logic [63:0]  x;
        logic [63:0]  s;
        logic [63:0]  r;
        coarse = HALF_PI_Q62 >> QUARTER_BITS;
        fine   = HALF_PI_Q62 & ((64'd1 << QUARTER_BITS) - 64'd1);
        for (int j = 0; j <= QUARTER_LEN; j++) begin
            x = coarse * 64'(j) + ((fine * 64'(j)) >> QUARTER_BITS);
            s = sine_q62(x);
            r = (mul_shr(AMPLITUDE, s, 61) + 64'd1) >> 1;
            if (r > AMPLITUDE) begin
                r = AMPLITUDE;
            end
            rom[j] = MAG_BITS'(r);
        end
        return rom;
    endfunction

endpackage

[sv/sine_tone_generator_core.sv]
// Sine tone generator: phase accumulator, quarter-wave ROM and per-channel output stage.
// Path: stage A (ROM read), then output register. Each frame item yields N channel copies,
//   N = channel count clamped to 1..8; the output register hands out one copy per cycle
//   while i_out_ready is high, so N = 1 allows an item every cycle.
// Reset: synchronous, active low; phase goes to zero, registers to their reset values and
//   both pipeline stages empty. The sine ROM is constant and needs no clearing pass.
module sine_tone_generator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // frame tick channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_in_restart,
    // sample channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [stg_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic [stg_pkg::CHAN_BITS-1:0]        o_out_channel,
    output logic                                 o_out_last,
    output logic                                 o_out_error,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [stg_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [stg_pkg::STEP_BITS-1:0]        i_cfg_data
);

    localparam stg_pkg::t_quarter_rom QUARTER_ROM = stg_pkg::build_quarter_rom();

    // Configuration registers
    logic [stg_pkg::STEP_BITS-1:0]  r_phase_step,    n_phase_step;
    logic [stg_pkg::COUNT_BITS-1:0] r_channel_count, n_channel_count;

    // Phase accumulator
    logic [stg_pkg::PHASE_BITS-1:0] r_phase, n_phase;

    // Stage A: ROM read result and sign/error flags for one frame
    logic                           r_a_valid, n_a_valid;
    logic                           r_a_neg;
    logic                           r_a_err;
    stg_pkg::t_mag                  r_rom_data;

    // Output register: one channel copy at a time
    logic                                   r_out_valid,   n_out_valid;
    logic signed [stg_pkg::SAMPLE_BITS-1:0] r_out_sample,  n_out_sample;
    logic [stg_pkg::CHAN_BITS-1:0]          r_out_channel, n_out_channel;
    logic                                   r_out_error,   n_out_error;

    // Combinational helpers
    logic [stg_pkg::PHASE_BITS-1:0]      phase_cur;
    logic                                step_bad;
    logic [stg_pkg::TABLE_ADDR_BITS-1:0] tab_k;
    logic [1:0]                          quad;
    logic [stg_pkg::QUARTER_BITS-1:0]    idx;
    logic [stg_pkg::ROM_ADDR_BITS-1:0]   rom_addr;
    logic [stg_pkg::CHAN_BITS-1:0]       last_ch;
    logic                                out_free;
    logic                                load_out;
    logic                                in_fire;
    logic                                cfg_fire;
    logic signed [stg_pkg::SAMPLE_BITS-1:0] mag_ext;
    logic signed [stg_pkg::SAMPLE_BITS-1:0] frame_sample;

    // Configuration port never stalls
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // Front end: phase for this frame, tuning word check and ROM address.
    // A restart clears the phase before the sample is taken.
    always_comb begin
        phase_cur = i_in_restart ? '0 : r_phase;
        step_bad  = (r_phase_step == '0) || (r_phase_step > stg_pkg::HALF_SCALE);
        tab_k     = phase_cur[stg_pkg::PHASE_BITS-1 -: stg_pkg::TABLE_ADDR_BITS];
        quad      = tab_k[stg_pkg::TABLE_ADDR_BITS-1 -: 2];
        idx       = tab_k[stg_pkg::QUARTER_BITS-1:0];
        // Odd quadrants walk the quarter table backward
        if (quad[0]) begin
            rom_addr = stg_pkg::ROM_ADDR_BITS'(stg_pkg::QUARTER_LEN) - {1'b0, idx};
        end else begin
            rom_addr = {1'b0, idx};
        end
    end

    // Index of the final channel copy: zero count acts as one, large counts clamp
    always_comb begin
        if (r_channel_count == '0) begin
            last_ch = '0;
        end else if (r_channel_count > stg_pkg::COUNT_BITS'(stg_pkg::MAX_CHANNELS)) begin
            last_ch = stg_pkg::CHAN_BITS'(stg_pkg::MAX_CHANNELS - 1);
        end else begin
            last_ch = stg_pkg::CHAN_BITS'(r_channel_count - stg_pkg::COUNT_BITS'(1));
        end
    end

    // Handshake: the output register takes a new frame once it is empty or its
    // final copy leaves; stage A refills in the same cycle it drains.
    always_comb begin
        out_free   = !r_out_valid || (i_out_ready && o_out_last);
        load_out   = r_a_valid && out_free;
        o_in_ready = !r_a_valid || load_out;
        in_fire    = i_in_valid && o_in_ready;
    end

    // Sign the magnitude for the lower half-wave; drop to zero on a bad tuning word
    always_comb begin
        mag_ext = signed'({1'b0, r_rom_data});
        if (r_a_err) begin
            frame_sample = '0;
        end else if (r_a_neg) begin
            frame_sample = -mag_ext;
        end else begin
            frame_sample = mag_ext;
        end
    end

    // Next-state logic
    always_comb begin
        n_phase_step    = r_phase_step;
        n_channel_count = r_channel_count;
        if (cfg_fire) begin
            case (i_cfg_index)
                stg_pkg::CFG_PHASE_STEP:    n_phase_step    = i_cfg_data;
                stg_pkg::CFG_CHANNEL_COUNT: n_channel_count = i_cfg_data[stg_pkg::COUNT_BITS-1:0];
                default:                    ;
            endcase
        end

        // Advance the phase only on a good tuning word; hold it otherwise
        n_phase = r_phase;
        if (in_fire) begin
            if (step_bad) begin
                n_phase = phase_cur;
            end else begin
                n_phase = phase_cur + stg_pkg::PHASE_BITS'(r_phase_step);
            end
        end

        n_a_valid = r_a_valid;
        if (in_fire) begin
            n_a_valid = 1'b1;
        end else if (load_out) begin
            n_a_valid = 1'b0;
        end

        n_out_valid   = r_out_valid;
        n_out_sample  = r_out_sample;
        n_out_channel = r_out_channel;
        n_out_error   = r_out_error;
        if (load_out) begin
            n_out_valid   = 1'b1;
            n_out_sample  = frame_sample;
            n_out_channel = '0;
            n_out_error   = r_a_err;
        end else if (r_out_valid && i_out_ready) begin
            if (o_out_last) begin
                n_out_valid = 1'b0;
            end else begin
                n_out_channel = r_out_channel + stg_pkg::CHAN_BITS'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= stg_pkg::PHASE_STEP_RESET;
            r_channel_count <= stg_pkg::CHANNEL_COUNT_RESET;
            r_phase         <= '0;
            r_a_valid       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase_step    <= n_phase_step;
            r_channel_count <= n_channel_count;
            r_phase         <= n_phase;
            r_a_valid       <= n_a_valid;
            r_out_valid     <= n_out_valid;
        end
    end

    // Payload registers, including the registered ROM read
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rom_data <= QUARTER_ROM[rom_addr];
            r_a_neg    <= quad[1];
            r_a_err    <= step_bad;
        end
        r_out_sample  <= n_out_sample;
        r_out_channel <= n_out_channel;
        r_out_error   <= n_out_error;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_out_channel = r_out_channel;
    assign o_out_last    = (r_out_channel == last_ch);
    assign o_out_error   = r_out_error;

`ifndef SYNTHESIS
    // A copy that is not the last is followed by the next channel of the same sample
    a_next_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_last) |=>
        (o_out_valid && (o_out_channel == $past(o_out_channel) + 3'd1) && $stable(o_out_sample)))
        else $error("channel copy sequence broken");

    // The channel index never passes the final copy
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_channel <= last_ch))
        else $error("channel index beyond channel count");

    // A bad tuning word yields silence
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_error) |-> (o_out_sample == '0))
        else $error("nonzero sample with error flag");
`endif

endmodule
